/* design/tnpb_pkg.sv */
package tnpb_pkg;

    // Branch decisions that ride along the divider pipeline
    typedef struct packed {
        logic swap;
        logic aa_le0;
        logic bb_le0;
        logic det_le0;
    } t_side;

    function automatic int f_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* design/triangle_nearest_point_barycentric_top.sv */
// Nearest point on a 3-D triangle as barycentric weights. Each beat on the
// input stream carries three vertices and a query point; each output beat
// carries the three Q1.FRAC_BITS weights and, in tuser, a flag that is set
// when the edge system is singular (then all weight goes to vertex two).
// The datapath is a fixed pipeline: nine stages of differences, dot products
// and split multipliers, then five parallel long dividers of FRAC_BITS+2
// stages each, an entry stage and then one quotient bit per stage. One beat
// is taken every cycle while the skid entry is empty. A one-entry skid stage
// behind the output register lets one more beat in while a result waits
// downstream.
module triangle_nearest_point_barycentric_top
    import tnpb_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, query_x, query_y, query_z
    input  logic [((12*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // weight_0, weight_1, weight_2
    output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] o_m_tdata,
    // degenerate
    output logic o_m_tuser
);
    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int DW  = CB + 1;
    localparam int PW  = 2*DW + 1;
    localparam int XW  = PW + 2;
    localparam int MW  = 2*PW;
    localparam int DTW = MW + 1;
    localparam int WW  = FB + 1;
    localparam int RW  = 3*WW + 1;
    localparam int OW  = ((3*WW+7)/8)*8;
    localparam int NV  = 9 + FB + 2;
    localparam int SL  = FB + 2;

    localparam int DOT_AA = 0;
    localparam int DOT_BB = 1;
    localparam int DOT_AB = 2;
    localparam int DOT_CA = 3;
    localparam int DOT_CB = 4;

    localparam int FB_T = 0;
    localparam int FB_S = 1;
    localparam int FB_E = 2;

    localparam logic [WW-1:0] ONE = {1'b1, {FB{1'b0}}};

    logic en;
    logic [NV-1:0] r_vld;

    logic signed [CB-1:0] v_in [12];

    logic signed [DW-1:0]   r1_d0 [3], r1_d1 [3];
    logic signed [CB-1:0]   r1_v0 [3], r1_v1 [3], r1_v2 [3], r1_q [3];
    logic signed [2*DW-1:0] r2_s0 [3], r2_s1 [3];
    logic signed [CB-1:0]   r2_v0 [3], r2_v1 [3], r2_v2 [3], r2_q [3];
    logic                   r3_swap;
    logic signed [CB-1:0]   r3_v0 [3], r3_v1 [3], r3_v2 [3], r3_q [3];
    logic signed [DW-1:0]   r4_e0 [3], r4_e1 [3], r4_c [3];
    logic                   r4_swap, r5_swap, r6_swap;
    logic signed [2*DW-1:0] r5_p [5][3];
    logic signed [PW-1:0]   r6_dot [5];
    logic signed [XW-1:0]   r7_fn [3], r7_fd [3], r8_fn [3], r8_fd [3];
    logic signed [XW-1:0]   r9_fn [3], r9_fd [3], n7_fn [3], n7_fd [3];
    t_side                  r7_side, r8_side, r9_side, n7_side, n9_side;
    logic signed [DTW-1:0]  r9_det, r9_sn, r9_tn, n9_det;
    t_side                  r_sl [0:SL-1];

    logic signed [PW-1:0]   aa3, bb3;
    logic signed [XW-1:0]   x_aa, x_bb, x_ab, x_ca, x_cb;
    logic signed [MW-1:0]   m_p [6];

    logic [WW-1:0] q_a, q_b, q_t, q_s, q_e;
    logic [WW-1:0] c_t, c_s, c_e, ws, wt, rest, w0, w1, w2;
    logic [WW:0]   sum_ab;
    logic          degen;
    t_side         side;
    logic [RW-1:0] n_res, r_od, r_sd;
    logic          r_ov, r_sv;

    assign en         = ~r_sv;
    assign o_s_tready = en;

    always_comb begin
        for (int j = 0; j < 12; j++) begin
            v_in[j] = i_s_tdata[j*CB +: CB];
        end
    end

    // Stage 3 compare operands: squared lengths of both edges
    always_comb begin
        aa3 = PW'(r2_s0[0]) + PW'(r2_s0[1]) + PW'(r2_s0[2]);
        bb3 = PW'(r2_s1[0]) + PW'(r2_s1[1]) + PW'(r2_s1[2]);
    end

    // Stage 7: fallback quotient operands and simple branch flags; stage 9 determinant and its sign flag
    always_comb begin
        x_aa = XW'(r6_dot[DOT_AA]);
        x_bb = XW'(r6_dot[DOT_BB]);
        x_ab = XW'(r6_dot[DOT_AB]);
        x_ca = XW'(r6_dot[DOT_CA]);
        x_cb = XW'(r6_dot[DOT_CB]);
        n7_fn[FB_T] = -x_cb;
        n7_fd[FB_T] = x_bb;
        n7_fn[FB_S] = -x_ca;
        n7_fd[FB_S] = x_aa;
        n7_fn[FB_E] = x_bb + x_cb - x_ab - x_ca;
        n7_fd[FB_E] = x_aa + x_bb - (x_ab <<< 1);
        n7_side.swap    = r6_swap;
        n7_side.aa_le0  = x_aa[XW-1] | ~(|x_aa);
        n7_side.bb_le0  = x_bb[XW-1] | ~(|x_bb);
        n7_side.det_le0 = 1'b0;
        n9_det  = DTW'(m_p[0]) - DTW'(m_p[1]);
        n9_side = r8_side;
        n9_side.det_le0 = n9_det[DTW-1] | ~(|n9_det);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                // stage 1
                r1_v0[k] <= v_in[k];
                r1_v1[k] <= v_in[3+k];
                r1_v2[k] <= v_in[6+k];
                r1_q[k]  <= v_in[9+k];
                r1_d0[k] <= DW'(v_in[6+k]) - DW'(v_in[k]);
                r1_d1[k] <= DW'(v_in[6+k]) - DW'(v_in[3+k]);
                // stage 2
                r2_s0[k] <= r1_d0[k] * r1_d0[k];
                r2_s1[k] <= r1_d1[k] * r1_d1[k];
                r2_v0[k] <= r1_v0[k];
                r2_v1[k] <= r1_v1[k];
                r2_v2[k] <= r1_v2[k];
                r2_q[k]  <= r1_q[k];
                // stage 3
                r3_v0[k] <= r2_v0[k];
                r3_v1[k] <= r2_v1[k];
                r3_v2[k] <= r2_v2[k];
                r3_q[k]  <= r2_q[k];
                // stage 5
                r5_p[DOT_AA][k] <= r4_e0[k] * r4_e0[k];
                r5_p[DOT_BB][k] <= r4_e1[k] * r4_e1[k];
                r5_p[DOT_AB][k] <= r4_e0[k] * r4_e1[k];
                r5_p[DOT_CA][k] <= r4_c[k] * r4_e0[k];
                r5_p[DOT_CB][k] <= r4_c[k] * r4_e1[k];
                // stages 7 to 9
                r7_fn[k] <= n7_fn[k];
                r7_fd[k] <= n7_fd[k];
                r8_fn[k] <= r7_fn[k];
                r8_fd[k] <= r7_fd[k];
                r9_fn[k] <= r8_fn[k];
                r9_fd[k] <= r8_fd[k];
            end
            r3_swap <= aa3 == bb3;
            r4_swap <= r3_swap;
            r5_swap <= r4_swap;
            r6_swap <= r5_swap;
            for (int j = 0; j < 5; j++) begin
                r6_dot[j] <= PW'(r5_p[j][0]) + PW'(r5_p[j][1]) + PW'(r5_p[j][2]);
            end
            r7_side <= n7_side;
            r8_side <= r7_side;
            r9_side <= n9_side;
            r9_det  <= n9_det;
            r9_sn   <= DTW'(m_p[2]) - DTW'(m_p[3]);
            r9_tn   <= DTW'(m_p[4]) - DTW'(m_p[5]);
            r_sl[0] <= r9_side;
            for (int j = 1; j < SL; j++) begin
                r_sl[j] <= r_sl[j-1];
            end
        end
    end

    // Stage 4: pick the labeling, then form edges and offset
    for (genvar k = 0; k < 3; k++) begin : g_lab
        logic signed [CB-1:0] la0, lb0, la1, lb1, lc;
        always_comb begin
            la0 = r3_swap ? r3_v1[k] : r3_v2[k];
            lb0 = r3_swap ? r3_v2[k] : r3_v0[k];
            la1 = r3_swap ? r3_v1[k] : r3_v2[k];
            lb1 = r3_swap ? r3_v0[k] : r3_v1[k];
            lc  = r3_swap ? r3_v1[k] : r3_v2[k];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r4_e0[k] <= DW'(la0) - DW'(lb0);
                r4_e1[k] <= DW'(la1) - DW'(lb1);
                r4_c[k]  <= DW'(r3_q[k]) - DW'(lc);
            end
        end
    end

    tnpb_mul #(.W(PW)) u_mul_det0 (
        .i_clk(i_clk), .i_en(en), .i_a(r6_dot[DOT_AA]), .i_b(r6_dot[DOT_BB]), .o_p(m_p[0]));
    tnpb_mul #(.W(PW)) u_mul_det1 (
        .i_clk(i_clk), .i_en(en), .i_a(r6_dot[DOT_AB]), .i_b(r6_dot[DOT_AB]), .o_p(m_p[1]));
    tnpb_mul #(.W(PW)) u_mul_s0 (
        .i_clk(i_clk), .i_en(en), .i_a(r6_dot[DOT_CB]), .i_b(r6_dot[DOT_AB]), .o_p(m_p[2]));
    tnpb_mul #(.W(PW)) u_mul_s1 (
        .i_clk(i_clk), .i_en(en), .i_a(r6_dot[DOT_CA]), .i_b(r6_dot[DOT_BB]), .o_p(m_p[3]));
    tnpb_mul #(.W(PW)) u_mul_t0 (
        .i_clk(i_clk), .i_en(en), .i_a(r6_dot[DOT_CA]), .i_b(r6_dot[DOT_AB]), .o_p(m_p[4]));
    tnpb_mul #(.W(PW)) u_mul_t1 (
        .i_clk(i_clk), .i_en(en), .i_a(r6_dot[DOT_CB]), .i_b(r6_dot[DOT_AA]), .o_p(m_p[5]));

    tnpb_div #(.NUM_W(DTW), .DEN_W(DTW), .FB(FB)) u_div_a (
        .i_clk(i_clk), .i_en(en), .i_num(r9_sn), .i_den(r9_det), .o_q(q_a));
    tnpb_div #(.NUM_W(DTW), .DEN_W(DTW), .FB(FB)) u_div_b (
        .i_clk(i_clk), .i_en(en), .i_num(r9_tn), .i_den(r9_det), .o_q(q_b));
    tnpb_div #(.NUM_W(XW), .DEN_W(XW), .FB(FB)) u_div_t (
        .i_clk(i_clk), .i_en(en), .i_num(r9_fn[FB_T]), .i_den(r9_fd[FB_T]), .o_q(q_t));
    tnpb_div #(.NUM_W(XW), .DEN_W(XW), .FB(FB)) u_div_s (
        .i_clk(i_clk), .i_en(en), .i_num(r9_fn[FB_S]), .i_den(r9_fd[FB_S]), .o_q(q_s));
    tnpb_div #(.NUM_W(XW), .DEN_W(XW), .FB(FB)) u_div_e (
        .i_clk(i_clk), .i_en(en), .i_num(r9_fn[FB_E]), .i_den(r9_fd[FB_E]), .o_q(q_e));

    // Branch selection and weight mapping at the end of the pipe
    always_comb begin
        side   = r_sl[SL-1];
        c_t    = (q_t > ONE) ? ONE : q_t;
        c_s    = (q_s > ONE) ? ONE : q_s;
        c_e    = (q_e > ONE) ? ONE : q_e;
        sum_ab = {1'b0, q_a} + {1'b0, q_b};
        degen  = 1'b0;
        ws     = '0;
        wt     = '0;
        if (side.aa_le0) begin
            wt = c_t;
        end else if (side.bb_le0) begin
            ws = c_s;
        end else if (side.det_le0) begin
            degen = 1'b1;
        end else if (q_a == '0) begin
            wt = c_t;
        end else if (q_b == '0) begin
            ws = c_s;
        end else if (sum_ab > {1'b0, ONE}) begin
            ws = c_e;
            wt = ONE - c_e;
        end else begin
            ws = q_a;
            wt = q_b;
        end
        rest = ONE - ws - wt;
        if (degen) begin
            w0 = '0;
            w1 = '0;
            w2 = ONE;
        end else if (!side.swap) begin
            w0 = ws;
            w1 = wt;
            w2 = rest;
        end else begin
            w0 = wt;
            w1 = rest;
            w2 = ws;
        end
        n_res = {degen, w2, w1, w0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_s_tvalid};
        end
    end

    // Output register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (i_m_tready) begin
                r_sv <= 1'b0;
            end
        end else if (r_vld[NV-1]) begin
            if (r_ov && !i_m_tready) begin
                r_sv <= 1'b1;
            end else begin
                r_ov <= 1'b1;
            end
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (i_m_tready) begin
                r_od <= r_sd;
            end
        end else if (r_vld[NV-1]) begin
            if (r_ov && !i_m_tready) begin
                r_sd <= n_res;
            end else begin
                r_od <= n_res;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OW'(r_od[3*WW-1:0]);
    assign o_m_tuser  = r_od[RW-1];

endmodule

/* design/tnpb_mul.sv */
module tnpb_mul #(
    parameter int W = 35
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [W-1:0]   i_a,
    input  logic signed [W-1:0]   i_b,
    output logic signed [2*W-1:0] o_p
);
    localparam int H  = (W + 1) / 2;
    localparam int HW = W - H;

    logic signed [HW-1:0]    a_hi, b_hi;
    logic signed [H:0]       a_lo, b_lo;
    logic signed [2*HW-1:0]  r_hh, n_hh;
    logic signed [HW+H:0]    r_hl, n_hl, r_lh, n_lh;
    logic signed [2*H+1:0]   r_ll, n_ll;
    logic signed [2*W-1:0]   r_p, n_p;

    // Split into a signed high half and an unsigned low half
    always_comb begin
        a_hi = i_a[W-1:H];
        b_hi = i_b[W-1:H];
        a_lo = {1'b0, i_a[H-1:0]};
        b_lo = {1'b0, i_b[H-1:0]};
        n_hh = a_hi * b_hi;
        n_hl = a_hi * b_lo;
        n_lh = a_lo * b_hi;
        n_ll = a_lo * b_lo;
        n_p  = ((2*W)'(r_hh) <<< (2*H))
             + (((2*W)'(r_hl) + (2*W)'(r_lh)) <<< H)
             + (2*W)'(r_ll);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= n_hh;
            r_hl <= n_hl;
            r_lh <= n_lh;
            r_ll <= n_ll;
            r_p  <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

/* design/tnpb_div.sv */
module tnpb_div
    import tnpb_pkg::*;
#(
    parameter int NUM_W = 37,
    parameter int DEN_W = 37,
    parameter int FB    = 16
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic signed [DEN_W-1:0] i_den,
    output logic [FB:0]             o_q
);
    localparam int CW  = f_max(NUM_W, DEN_W) + FB + 1;
    localparam int NST = FB + 1;
    localparam logic [FB:0] CAP = {1'b1, {(FB-1){1'b0}}, 1'b1};

    logic [CW-1:0]    r_rem  [0:NST-1];
    logic [DEN_W-1:0] r_den  [0:NST-1];
    logic [FB:0]      r_q    [0:NST];
    logic             r_zero [0:NST];
    logic             r_cap  [0:NST];

    logic [CW-1:0] n0, dz, lim;
    logic          num_pos, den_pos;

    // Entry: reject non-positive operands, saturate at one plus one LSB
    always_comb begin
        num_pos = ~i_num[NUM_W-1] & (|i_num);
        den_pos = ~i_den[DEN_W-1] & (|i_den);
        n0  = {{(CW-NUM_W){1'b0}}, i_num} << FB;
        dz  = {{(CW-DEN_W){1'b0}}, i_den};
        lim = (dz << FB) + dz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= n0;
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_zero[0] <= ~(num_pos & den_pos);
            r_cap[0]  <= n0 >= lim;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= NST; k++) begin : g_step
        localparam int SH = NST - k;
        logic [CW-1:0] sh, n_rem;
        logic [FB:0]   n_q;
        logic          ge;
        always_comb begin
            sh    = {{(CW-DEN_W){1'b0}}, r_den[k-1]} << SH;
            ge    = r_rem[k-1] >= sh;
            n_rem = ge ? (r_rem[k-1] - sh) : r_rem[k-1];
            n_q   = r_q[k-1];
            n_q[SH] = ge;
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]    <= n_q;
                r_zero[k] <= r_zero[k-1];
                r_cap[k]  <= r_cap[k-1];
            end
        end
        if (k < NST) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= n_rem;
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    assign o_q = r_zero[NST] ? '0 : (r_cap[NST] ? CAP : r_q[NST]);

endmodule

/* sim/tb_triangle_nearest_point_barycentric_top.sv */
module tb_triangle_nearest_point_barycentric_top;
    import tnpb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int IN_W = ((12*CB+7)/8)*8;
    localparam int OUT_W = ((3*(FB+1)+7)/8)*8;
    localparam int ONE = 1 << FB;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [CB-1:0] t_coord;
    typedef t_coord t_query [12];

    typedef struct packed {
        logic [FB:0] w0;
        logic [FB:0] w1;
        logic [FB:0] w2;
        logic        degen;
    } t_weights;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [IN_W-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [OUT_W-1:0] o_m_tdata;
    logic o_m_tuser;

    triangle_nearest_point_barycentric_top #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_weights pending_weights[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    bit       long_hold_req = 1'b0;

    // Truncated num*2^FB/den, zero for non-positive operands, capped one LSB above one
    function automatic logic [FB:0] frac_quot(t_wide num, t_wide den);
        t_wide cap;
        t_wide shifted;
        cap = t_wide'(ONE + 1);
        if (den <= 0 || num <= 0) return '0;
        shifted = num <<< FB;
        if (shifted >= den * cap) return (FB+1)'(ONE + 1);
        return (FB+1)'(shifted / den);
    endfunction

    function automatic logic [FB:0] sat_one(logic [FB:0] v);
        return (v > ONE) ? (FB+1)'(ONE) : v;
    endfunction

    function automatic t_wide dot3(t_wide a[3], t_wide b[3]);
        return a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    endfunction

    function automatic t_weights nearest_weights(t_query c);
        t_wide e0[3], e1[3], cv[3];
        t_wide aa, bb, ab, ca, cb, det;
        logic [FB:0] ws, wt, qa, qb;
        logic relabel;
        t_weights r;
        ws = '0;
        wt = '0;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            e0[k] = t_wide'(c[6+k]) - t_wide'(c[k]);
            e1[k] = t_wide'(c[6+k]) - t_wide'(c[3+k]);
            cv[k] = t_wide'(c[9+k]) - t_wide'(c[6+k]);
        end
        relabel = (dot3(e0, e0) == dot3(e1, e1));
        if (relabel) begin
            for (int k = 0; k < 3; k++) begin
                e0[k] = t_wide'(c[3+k]) - t_wide'(c[6+k]);
                e1[k] = t_wide'(c[3+k]) - t_wide'(c[k]);
                cv[k] = t_wide'(c[9+k]) - t_wide'(c[3+k]);
            end
        end
        aa = dot3(e0, e0);
        bb = dot3(e1, e1);
        ab = dot3(e0, e1);
        ca = dot3(cv, e0);
        cb = dot3(cv, e1);
        if (aa <= 0) begin
            wt = sat_one(frac_quot(-cb, bb));
        end else if (bb <= 0) begin
            ws = sat_one(frac_quot(-ca, aa));
        end else begin
            det = aa*bb - ab*ab;
            if (det <= 0) begin
                r.degen = 1'b1;
            end else begin
                qa = frac_quot(cb*ab - ca*bb, det);
                qb = frac_quot(ca*ab - cb*aa, det);
                if (qa == 0) begin
                    wt = sat_one(frac_quot(-cb, bb));
                end else if (qb == 0) begin
                    ws = sat_one(frac_quot(-ca, aa));
                end else if (int'(qa) + int'(qb) > ONE) begin
                    ws = sat_one(frac_quot(-(ab + ca - bb - cb), aa + bb - 2*ab));
                    wt = (FB+1)'(ONE - int'(ws));
                end else begin
                    ws = qa;
                    wt = qb;
                end
            end
        end
        if (r.degen) begin
            r.w2 = (FB+1)'(ONE);
        end else if (!relabel) begin
            r.w0 = ws;
            r.w1 = wt;
            r.w2 = (FB+1)'(ONE - int'(ws) - int'(wt));
        end else begin
            r.w2 = ws;
            r.w0 = wt;
            r.w1 = (FB+1)'(ONE - int'(ws) - int'(wt));
        end
        return r;
    endfunction

    task automatic send_query(t_query c);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        for (int k = 0; k < 12; k++) i_s_tdata[k*CB +: CB] = c[k];
        i_s_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_weights.push_back(nearest_weights(c));
    endtask

    function automatic t_query rand_query(int span);
        t_query c;
        int base;
        base = $urandom_range(0, 65535) - 32768;
        for (int k = 0; k < 12; k++) begin
            if (span >= 65536) c[k] = t_coord'($urandom);
            else c[k] = t_coord'(base + $urandom_range(0, span) - span/2);
        end
        return c;
    endfunction

    // v0 and v1 at offsets from v2 that are permutations of one another give equal edge lengths
    function automatic t_query isosceles_query(int span);
        t_query c;
        int d[3];
        c = rand_query(span);
        for (int k = 0; k < 3; k++) d[k] = $urandom_range(0, span/4) - span/8;
        for (int k = 0; k < 3; k++) begin
            c[k]   = t_coord'(int'(c[6+k]) + d[k]);
            c[3+k] = t_coord'(int'(c[6+k]) + d[(k+1)%3]);
        end
        return c;
    endfunction

    // v1 on the line through v2 and v0
    function automatic t_query collinear_query(int span);
        t_query c;
        int m;
        c = rand_query(span);
        m = $urandom_range(0, 4) - 2;
        for (int k = 0; k < 3; k++) begin
            c[k]   = t_coord'(int'(c[6+k]) + $signed($urandom_range(0, 40)) - 20);
            c[3+k] = t_coord'(int'(c[6+k]) + m * (int'(c[k]) - int'(c[6+k])));
        end
        return c;
    endfunction

    function automatic t_query make_query(int a0, int a1, int a2, int b0, int b1, int b2,
                                          int c0, int c1, int c2, int q0, int q1, int q2);
        t_query c;
        c = '{t_coord'(a0), t_coord'(a1), t_coord'(a2), t_coord'(b0), t_coord'(b1),
              t_coord'(b2), t_coord'(c0), t_coord'(c1), t_coord'(c2), t_coord'(q0),
              t_coord'(q1), t_coord'(q2)};
        return c;
    endfunction

    task automatic test_directed();
        send_query(make_query(32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767, 32767, 32767, 32767));
        send_query(make_query(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768, 32767, 32767, 32767));
        send_query(make_query(-32768, 32767, -32768, 32767, -32768, 32767,
                              -32768, -32768, 32767, 32767, 32767, -32768));
        send_query(make_query(-32768, -32768, 0, 32767, -32768, 0,
                              0, 32767, 0, 0, 0, 32767));
        // inside, on each vertex, past each edge
        send_query(make_query(0, 0, 0, 100, 0, 0, 0, 70, 0, 20, 20, 9));
        send_query(make_query(0, 0, 0, 100, 0, 0, 0, 70, 0, 0, 0, 0));
        send_query(make_query(0, 0, 0, 100, 0, 0, 0, 70, 0, 100, 0, 5));
        send_query(make_query(0, 0, 0, 100, 0, 0, 0, 70, 0, 0, 70, -5));
        send_query(make_query(0, 0, 0, 100, 0, 0, 0, 70, 0, 300, 300, 0));
        send_query(make_query(0, 0, 0, 100, 0, 0, 0, 70, 0, -50, 30, 0));
        send_query(make_query(0, 0, 0, 100, 0, 0, 0, 70, 0, 40, -50, 0));
        send_query(make_query(0, 0, 0, 100, 0, 0, 0, 70, 0, -500, -500, 1));
        // equal edge lengths: relabel around vertex one
        send_query(make_query(10, 0, 0, 0, 10, 0, 0, 0, 0, 3, 3, 3));
        send_query(make_query(10, 0, 0, 0, 10, 0, 0, 0, 0, 30, 30, 0));
        send_query(make_query(32767, 0, 0, 0, 32767, 0, 0, 0, 0, -32768, -32768, 0));
        // collinear: degenerate
        send_query(make_query(0, 0, 0, 20, 20, 20, 10, 10, 10, 5, -3, 7));
        send_query(make_query(-32768, 0, 0, 32767, 0, 0, 0, 0, 0, 1, 1, 1));
        // collapsed edges
        send_query(make_query(5, 5, 5, 50, -20, 9, 5, 5, 5, 30, 0, 0));
        send_query(make_query(-7, 40, 3, 2, 2, 2, 2, 2, 2, -100, 90, 0));
        send_query(make_query(1, 2, 3, 1, 2, 3, 1, 2, 3, 4, 5, 6));
    endtask

    task automatic test_random(int count);
        int pick;
        int span;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 9);
            span = ($urandom_range(0, 2) == 0) ? 65536 : (1 << $urandom_range(3, 15));
            if (pick < 6)      send_query(rand_query(span));
            else if (pick < 8) send_query(isosceles_query(span < 65536 ? span : 4096));
            else               send_query(collinear_query(span < 65536 ? span : 4096));
        end
    endtask

    task automatic test_backpressure();
        long_hold_req = 1'b1;
        burst_left = 0;
        test_random(60);
    endtask

    // receiver: random stall pattern that changes mode now and then
    always @(negedge i_clk) begin
        static int hold_cycles = 0;
        static int mode = 0;
        static int mode_left = 0;
        if (hold_cycles > 0) begin
            hold_cycles--;
            i_m_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cycles = 300;
            i_m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
                0: i_m_tready <= 1'b1;
                1: i_m_tready <= 1'($urandom_range(0, 1));
                default: i_m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_weights want;
        t_weights got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.w0 = o_m_tdata[0 +: FB+1];
            got.w1 = o_m_tdata[FB+1 +: FB+1];
            got.w2 = o_m_tdata[2*(FB+1) +: FB+1];
            got.degen = o_m_tuser;
            if (pending_weights.size() == 0) begin
                $error("output beat with no pending result");
                error_count++;
            end else begin
                want = pending_weights.pop_front();
                if (got.w0 !== want.w0) begin
                    $error("weight_0 expected %0d got %0d", want.w0, got.w0);
                    error_count++;
                end
                if (got.w1 !== want.w1) begin
                    $error("weight_1 expected %0d got %0d", want.w1, got.w1);
                    error_count++;
                end
                if (got.w2 !== want.w2) begin
                    $error("weight_2 expected %0d got %0d", want.w2, got.w2);
                    error_count++;
                end
                if (got.degen !== want.degen) begin
                    $error("degenerate expected %0d got %0d", want.degen, got.degen);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(1270);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (pending_weights.size() != 0) @(posedge i_clk);
        repeat (2*FB + 24) @(posedge i_clk);
        if (error_count == 0 && pending_weights.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
